// ===== rtl/tbig_pkg.sv =====
// Shared constants and types for the triangle basis inverse gradient block.
// No dependencies; used by triangle_basis_inverse_gradient.
package tbig_pkg;

	localparam int IN_FRAC_BITS  = 14;
	localparam int OUT_FRAC_BITS = 16;
	localparam int FRAC_STEPS    = IN_FRAC_BITS + OUT_FRAC_BITS;
	localparam int DIV_STEPS     = 32;                       // quotient bits kept before rounding
	localparam int INT_STEPS     = DIV_STEPS - FRAC_STEPS;   // integer quotient bits
	localparam int NUM_LANES     = 6;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int COF_W  = PROD_W + 1;
	localparam int NUM_W  = COF_W + 1;
	localparam int UN_W   = NUM_W - 1;
	localparam int DET_W  = ELEM_W + COF_W;
	localparam int UD_W   = DET_W - 1;
	localparam int REM_W  = UD_W + 3;
	localparam int Q_W    = DIV_STEPS;
	localparam int OUT_W  = 32;

	// accept edge to strobe: four arithmetic stages, setup, divide steps, output
	localparam int LATENCY = 5 + DIV_STEPS + 1;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic signed [NUM_W-1:0]  num_t;
	typedef logic signed [DET_W-1:0]  det_t;
	typedef logic        [REM_W-1:0]  rem_t;
	typedef logic        [Q_W-1:0]    quot_t;
	typedef logic signed [OUT_W-1:0]  grad_t;

	localparam grad_t GRAD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam grad_t GRAD_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== rtl/triangle_basis_inverse_gradient.sv =====
// Triangle basis inverse gradient: 3x3 cofactor inverse times a fixed matrix.
// Depends on tbig_pkg for widths, latency and saturation limits.
//
// Usage: raise start with a triangle on the input ports; busy is always low,
// so a transaction is accepted at every edge where start is high and a new
// triangle may enter every cycle. Each transaction produces exactly one
// result, shown for one cycle with done high; the receiver cannot stall, so
// capture on done. The divider computes one restoring quotient bit per stage
// for 32 stages, six lanes side by side, behind four cofactor/determinant
// stages, one setup stage and one rounding/saturation output stage. Results
// are round-to-nearest (ties away from zero) in Q15.16, clipped to 32 bits
// with saturated raised.
// A zero determinant gives singular high and all gradient entries zero.
module triangle_basis_inverse_gradient (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] face_tag,
	input  logic signed [15:0] edge_a_x,
	input  logic signed [15:0] edge_a_y,
	input  logic signed [15:0] edge_a_z,
	input  logic signed [15:0] edge_b_x,
	input  logic signed [15:0] edge_b_y,
	input  logic signed [15:0] edge_b_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic        done,
	output logic [15:0] face_tag_out,
	output logic signed [31:0] grad_r0_c0,
	output logic signed [31:0] grad_r1_c0,
	output logic signed [31:0] grad_r2_c0,
	output logic signed [31:0] grad_r0_c1,
	output logic signed [31:0] grad_r1_c1,
	output logic signed [31:0] grad_r2_c1,
	output logic        singular,
	output logic        saturated
);

	localparam int NL = tbig_pkg::NUM_LANES;
	localparam int DS = tbig_pkg::DIV_STEPS;

	// never stalls: every cycle takes a new transaction
	assign busy = 1'b0;

	tbig_pkg::elem_t e [3][3];
	always_comb begin
		e[0][0] = edge_a_x;  e[0][1] = edge_a_y;  e[0][2] = edge_a_z;
		e[1][0] = edge_b_x;  e[1][1] = edge_b_y;  e[1][2] = edge_b_z;
		e[2][0] = normal_x;  e[2][1] = normal_y;  e[2][2] = normal_z;
	end

	// ---------------- stage 1: cofactor products ----------------
	// Column j of the unscaled inverse is row (j+1) cross row (j+2).
	logic                 vld_s1;
	logic [15:0]          tag_s1;
	tbig_pkg::elem_t      e0_s1 [3];
	tbig_pkg::prod_t      pa_s1 [3][3];
	tbig_pkg::prod_t      pb_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_cof_col
		for (genvar i = 0; i < 3; i++) begin : g_cof_row
			localparam int P  = (j + 1) % 3;
			localparam int S  = (j + 2) % 3;
			localparam int A1 = (i + 1) % 3;
			localparam int A2 = (i + 2) % 3;
			always_ff @(posedge clk) begin
				pa_s1[i][j] <= e[P][A1] * e[S][A2];
				pb_s1[i][j] <= e[P][A2] * e[S][A1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s1   <= face_tag;
		e0_s1[0] <= e[0][0];
		e0_s1[1] <= e[0][1];
		e0_s1[2] <= e[0][2];
	end

	// ---------------- stage 2: cofactors ----------------
	logic            vld_s2;
	logic [15:0]     tag_s2;
	tbig_pkg::elem_t e0_s2 [3];
	tbig_pkg::cof_t  cof_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		e0_s2  <= e0_s1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof_s2[i][j] <= tbig_pkg::COF_W'(pa_s1[i][j]) - tbig_pkg::COF_W'(pb_s1[i][j]);
			end
		end
	end

	// ---------------- stage 3: determinant terms and numerators ----------------
	// Lane l = c*3 + i holds inverse column c+1 minus column 0, row i.
	logic            vld_s3;
	logic [15:0]     tag_s3;
	tbig_pkg::det_t  dterm_s3 [3];
	tbig_pkg::num_t  num_s3 [NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag_s2;
		for (int j = 0; j < 3; j++) begin
			dterm_s3[j] <= tbig_pkg::DET_W'(e0_s2[j]) * tbig_pkg::DET_W'(cof_s2[j][0]);
		end
		for (int c = 0; c < 2; c++) begin
			for (int i = 0; i < 3; i++) begin
				num_s3[c*3+i] <= tbig_pkg::NUM_W'(cof_s2[i][c+1])
					- tbig_pkg::NUM_W'(cof_s2[i][0]);
			end
		end
	end

	// ---------------- stage 4: determinant, magnitudes and signs ----------------
	logic                   vld_s4;
	logic [15:0]            tag_s4;
	logic                   zero_s4;
	logic                   dneg_s4;
	logic [tbig_pkg::UD_W-1:0] ud_s4;
	logic [tbig_pkg::UN_W-1:0] un_s4 [NL];
	logic                   nneg_s4 [NL];
	tbig_pkg::det_t         det_c;
	tbig_pkg::det_t         det_abs_c;

	always_comb begin
		det_c     = dterm_s3[0] + dterm_s3[1] + dterm_s3[2];
		det_abs_c = det_c[tbig_pkg::DET_W-1] ? -det_c : det_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4  <= tag_s3;
		zero_s4 <= (det_c == '0);
		dneg_s4 <= det_c[tbig_pkg::DET_W-1];
		ud_s4   <= det_abs_c[tbig_pkg::UD_W-1:0];
		for (int l = 0; l < NL; l++) begin
			nneg_s4[l] <= num_s3[l][tbig_pkg::NUM_W-1];
			un_s4[l]   <= num_s3[l][tbig_pkg::NUM_W-1]
				? tbig_pkg::UN_W'(-num_s3[l]) : tbig_pkg::UN_W'(num_s3[l]);
		end
	end

	// ---------------- stage 5 and divide steps ----------------
	// Index 0 is the setup stage; index k+1 holds the state after quotient bit k.
	logic                      vld_sd  [DS+1];
	logic [15:0]               tag_sd  [DS+1];
	logic                      zero_sd [DS+1];
	tbig_pkg::rem_t            ud_sd   [DS+1];
	tbig_pkg::rem_t            rem_sd  [DS+1][NL];
	tbig_pkg::quot_t           q_sd    [DS+1][NL];
	logic                      neg_sd  [DS+1][NL];
	logic                      big_sd  [DS+1][NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else begin
			vld_sd[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_sd[0]  <= tag_s4;
		zero_sd[0] <= zero_s4;
		ud_sd[0]   <= tbig_pkg::REM_W'(ud_s4);
		for (int l = 0; l < NL; l++) begin
			rem_sd[0][l] <= tbig_pkg::REM_W'(un_s4[l]);
			q_sd[0][l]   <= '0;
			neg_sd[0][l] <= nneg_s4[l] ^ dneg_s4;
			// quotient at or above 2^DIV_STEPS clips regardless of rounding
			big_sd[0][l] <= tbig_pkg::REM_W'(un_s4[l])
				>= (tbig_pkg::REM_W'(ud_s4) << tbig_pkg::INT_STEPS);
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		localparam int SH = (k < tbig_pkg::INT_STEPS) ? (tbig_pkg::INT_STEPS - 1 - k) : 0;
		tbig_pkg::rem_t trial [NL];
		tbig_pkg::rem_t dsr;
		logic           ge [NL];

		always_comb begin
			dsr = ud_sd[k] << SH;
			for (int l = 0; l < NL; l++) begin
				trial[l] = (k >= tbig_pkg::INT_STEPS) ? (rem_sd[k][l] << 1) : rem_sd[k][l];
				ge[l]    = trial[l] >= dsr;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_sd[k+1]  <= tag_sd[k];
			zero_sd[k+1] <= zero_sd[k];
			ud_sd[k+1]   <= ud_sd[k];
			for (int l = 0; l < NL; l++) begin
				rem_sd[k+1][l] <= ge[l] ? (trial[l] - dsr) : trial[l];
				q_sd[k+1][l]   <= {q_sd[k][l][tbig_pkg::Q_W-2:0], ge[l]};
				neg_sd[k+1][l] <= neg_sd[k][l];
				big_sd[k+1][l] <= big_sd[k][l];
			end
		end
	end

	// ---------------- output stage: round, sign, saturate ----------------
	tbig_pkg::grad_t     val_c [NL];
	logic                sat_c [NL];
	logic                any_sat_c;
	logic [tbig_pkg::Q_W:0] qr_c [NL];

	always_comb begin
		any_sat_c = 1'b0;
		for (int l = 0; l < NL; l++) begin
			// ties go away from zero: round the magnitude up on half or more
			qr_c[l] = {1'b0, q_sd[DS][l]}
				+ (tbig_pkg::Q_W+1)'((rem_sd[DS][l] << 1) >= ud_sd[DS]);
			sat_c[l] = 1'b0;
			if (neg_sd[DS][l]) begin
				if (big_sd[DS][l] || qr_c[l] > (tbig_pkg::Q_W+1)'(33'h0_8000_0000)) begin
					sat_c[l] = 1'b1;
					val_c[l] = tbig_pkg::GRAD_MIN;
				end else begin
					val_c[l] = tbig_pkg::OUT_W'(-qr_c[l]);
				end
			end else begin
				if (big_sd[DS][l] || qr_c[l] > (tbig_pkg::Q_W+1)'(33'h0_7FFF_FFFF)) begin
					sat_c[l] = 1'b1;
					val_c[l] = tbig_pkg::GRAD_MAX;
				end else begin
					val_c[l] = tbig_pkg::OUT_W'(qr_c[l]);
				end
			end
			// singular: zero every entry, no clipping reported
			if (zero_sd[DS]) begin
				sat_c[l] = 1'b0;
				val_c[l] = '0;
			end
			any_sat_c = any_sat_c | sat_c[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sd[DS];
		end
	end

	always_ff @(posedge clk) begin
		face_tag_out <= tag_sd[DS];
		grad_r0_c0   <= val_c[0];
		grad_r1_c0   <= val_c[1];
		grad_r2_c0   <= val_c[2];
		grad_r0_c1   <= val_c[3];
		grad_r1_c1   <= val_c[4];
		grad_r2_c1   <= val_c[5];
		singular     <= zero_sd[DS];
		saturated    <= any_sat_c;
	end

`ifndef ASSERT_OFF
	// a result appears only for a transaction accepted exactly one latency earlier
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, tbig_pkg::LATENCY))
		else $error("result strobe without matching accepted transaction");

	// singular results carry zero entries and never report clipping
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && singular) |-> (!saturated && grad_r0_c0 == '0 && grad_r1_c0 == '0
			&& grad_r2_c0 == '0 && grad_r0_c1 == '0 && grad_r1_c1 == '0
			&& grad_r2_c1 == '0))
		else $error("singular result with nonzero entries or saturation");

	// a clipped result has at least one entry sitting at a rail
	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (grad_r0_c0 == tbig_pkg::GRAD_MAX || grad_r0_c0 == tbig_pkg::GRAD_MIN
			|| grad_r1_c0 == tbig_pkg::GRAD_MAX || grad_r1_c0 == tbig_pkg::GRAD_MIN
			|| grad_r2_c0 == tbig_pkg::GRAD_MAX || grad_r2_c0 == tbig_pkg::GRAD_MIN
			|| grad_r0_c1 == tbig_pkg::GRAD_MAX || grad_r0_c1 == tbig_pkg::GRAD_MIN
			|| grad_r1_c1 == tbig_pkg::GRAD_MAX || grad_r1_c1 == tbig_pkg::GRAD_MIN
			|| grad_r2_c1 == tbig_pkg::GRAD_MAX || grad_r2_c1 == tbig_pkg::GRAD_MIN))
		else $error("saturation flagged with no entry at a rail");
`endif

endmodule
